// ----- rtl/epd_pkg.sv -----
// ----------------------------------------------------------------------------
// epd_pkg
// Shared constants and types for the EEG packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

    localparam int BYTE_W           = 8;
    localparam int SAMPLE_W         = 24;
    localparam int CHANNEL_W        = 3;
    localparam int BYTES_PER_SAMPLE = 3;

    localparam int DEF_NUM_CHANNELS = 8;
    localparam int DEF_AUX_BYTES    = 6;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hA0;
    localparam logic [BYTE_W-1:0] FOOTER_MASK = 8'hC0;

    typedef logic [BYTE_W-1:0]           byte_t;
    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic [CHANNEL_W-1:0]        channel_t;

endpackage

// ----- rtl/epd_ifs.sv -----
// ----------------------------------------------------------------------------
// epd_ifs
// Valid/ready channels for received bytes and for decoded channel samples.
// ----------------------------------------------------------------------------
interface epd_byte_if
    import epd_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface epd_sample_if
    import epd_pkg::*;
();
    logic     valid;
    logic     ready;
    channel_t channel;
    sample_t  sample_value;
    logic     last;

    modport source (output valid, output channel, output sample_value, output last,
                    input ready);
    modport sink   (input valid, input channel, input sample_value, input last,
                    output ready);
endinterface

// ----- rtl/epd_front.sv -----
// ----------------------------------------------------------------------------
// epd_front
// Packet framing state machine; gathers channel samples and pushes a packet
// on a good footer.
// ----------------------------------------------------------------------------
module epd_front
    import epd_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int AUX_BYTES    = DEF_AUX_BYTES
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    epd_byte_if.sink                             in_bytes,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] push_data
);

    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AUX_W    = (AUX_BYTES > 1) ? $clog2(AUX_BYTES) : 1;
    localparam int AUX_LAST = (AUX_BYTES > 0) ? AUX_BYTES - 1 : 0;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEQ    = 3'd1;
    localparam logic [2:0] ST_DATA   = 3'd2;
    localparam logic [2:0] ST_AUX    = 3'd3;
    localparam logic [2:0] ST_FOOTER = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CH_W-1:0]  ch_cnt_reg, ch_cnt_next;
    logic [1:0]       byte_cnt_reg, byte_cnt_next;
    logic [AUX_W-1:0] aux_cnt_reg, aux_cnt_next;
    logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] lane_reg;
    logic             accept;
    logic             footer_ok;

    assign in_bytes.ready = (state_reg != ST_FOOTER) || push_ready;
    assign accept         = in_bytes.valid && in_bytes.ready;
    assign footer_ok      = (in_bytes.rx_byte & FOOTER_MASK) == FOOTER_MASK;
    assign push_valid     = in_bytes.valid && (state_reg == ST_FOOTER) && footer_ok;
    assign push_data      = lane_reg;

    always_comb
    begin
        state_next    = state_reg;
        ch_cnt_next   = ch_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        aux_cnt_next  = aux_cnt_reg;
        if (accept)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_bytes.rx_byte == HEADER_BYTE)
                    begin
                        state_next = ST_SEQ;
                    end
                end
                ST_SEQ:
                begin
                    state_next    = ST_DATA;
                    ch_cnt_next   = '0;
                    byte_cnt_next = '0;
                end
                ST_DATA:
                begin
                    if (byte_cnt_reg == 2'(BYTES_PER_SAMPLE - 1))
                    begin
                        byte_cnt_next = '0;
                        ch_cnt_next   = ch_cnt_reg + 1'b1;
                        if (ch_cnt_reg == CH_W'(NUM_CHANNELS - 1))
                        begin
                            aux_cnt_next = '0;
                            state_next   = (AUX_BYTES > 0) ? ST_AUX : ST_FOOTER;
                        end
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 1'b1;
                    end
                end
                ST_AUX:
                begin
                    aux_cnt_next = aux_cnt_reg + 1'b1;
                    if (aux_cnt_reg == AUX_W'(AUX_LAST))
                    begin
                        state_next = ST_FOOTER;
                    end
                end
                ST_FOOTER:
                begin
                    // good or bad footer, the packet ends here
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ch_cnt_reg   <= '0;
            byte_cnt_reg <= '0;
            aux_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ch_cnt_reg   <= ch_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            aux_cnt_reg  <= aux_cnt_next;
        end
    end

    // sample lanes, big-endian byte order
    always_ff @(posedge clk)
    begin
        if (accept && (state_reg == ST_DATA))
        begin
            case (byte_cnt_reg)
                2'd0:    lane_reg[ch_cnt_reg][23:16] <= in_bytes.rx_byte;
                2'd1:    lane_reg[ch_cnt_reg][15:8]  <= in_bytes.rx_byte;
                default: lane_reg[ch_cnt_reg][7:0]   <= in_bytes.rx_byte;
            endcase
        end
    end

endmodule

// ----- rtl/epd_queue.sv -----
// ----------------------------------------------------------------------------
// epd_queue
// Two-entry packet queue between the framer and the sample emitter.
// ----------------------------------------------------------------------------
module epd_queue
    import epd_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push_valid,
    output logic                                  push_ready,
    input  logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] push_data,
    output logic                                  pop_valid,
    input  logic                                  pop_ready,
    output logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] pop_data
);

    logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/epd_back.sv -----
// ----------------------------------------------------------------------------
// epd_back
// Unpacks one queued packet into per-channel sample words.
// ----------------------------------------------------------------------------
module epd_back
    import epd_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] pop_data,
    epd_sample_if.source                          out_samples
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] pkt_reg;
    logic            busy_reg, busy_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            out_valid_reg, out_valid_next;
    channel_t        out_channel_reg;
    sample_t         out_sample_reg;
    logic            out_last_reg;
    logic            advance;
    logic            at_last;
    logic            load;

    assign advance   = busy_reg && (!out_valid_reg || out_samples.ready);
    assign at_last   = (ch_reg == CH_W'(NUM_CHANNELS - 1));
    assign pop_ready = !busy_reg || (advance && at_last);
    assign load      = pop_valid && pop_ready;

    assign out_samples.valid        = out_valid_reg;
    assign out_samples.channel      = out_channel_reg;
    assign out_samples.sample_value = out_sample_reg;
    assign out_samples.last         = out_last_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        if (out_samples.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            ch_next        = ch_reg + 1'b1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            ch_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= pop_data;
        end
        if (advance)
        begin
            out_channel_reg <= CHANNEL_W'(ch_reg);
            out_sample_reg  <= $signed(pkt_reg[ch_reg]);
            out_last_reg    <= at_last;
        end
    end

endmodule

// ----- rtl/eeg_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// eeg_packet_deframer
// Byte-serial deframer for EEG packets carrying signed 24-bit channel samples.
// ----------------------------------------------------------------------------
// packet path: footer -> queue slot -> packet register -> output register
// throughput: one byte per cycle in, one sample word per cycle out while ready
// the byte input stalls only on a footer while both packet queue slots are full
// a good packet of 3 + 3*NUM_CHANNELS + AUX_BYTES bytes yields NUM_CHANNELS samples
// reset: framer returns to header search, queue and output are emptied
// no clearing pass; sample lanes are always written before they are read
module eeg_packet_deframer
    import epd_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int AUX_BYTES    = DEF_AUX_BYTES
)
(
    input  logic          clk,
    input  logic          rst_n,
    epd_byte_if.sink      in_bytes,
    epd_sample_if.source  out_samples
);

    // framer to queue
    logic                                  push_valid;
    logic                                  push_ready;
    logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] push_data;

    // queue to emitter
    logic                                  pop_valid;
    logic                                  pop_ready;
    logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] pop_data;

    // front: header search, byte counting, sample assembly, footer check
    epd_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AUX_BYTES    (AUX_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_bytes   (in_bytes),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // queue: holds whole accepted packets so new bytes may keep arriving
    epd_queue #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: one sample word per channel, last flag on the final channel
    epd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_samples (out_samples)
    );

endmodule
